// File: hw/rtl/qau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qau_pkg;

  localparam int DEF_COMPONENT_BITS = 32;
  localparam int DEF_FRACTION_BITS  = 16;

  localparam int              MIN_MAG_BITS  = 17;
  localparam logic [16:0]     MIN_MAG_RESET = 17'd66;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_CONJ = 3'd3,
    CMD_ROT  = 3'd4,
    CMD_MAG  = 3'd5,
    CMD_NORM = 3'd6
  } cmd_t;

  // Hamilton product: row r of p*q sums sign * p[j] * q[Q_INDEX[r][j]]
  localparam logic [1:0] Q_INDEX [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd3, 2'd0, 2'd1},
    '{2'd3, 2'd2, 2'd1, 2'd0}
  };

  localparam logic Q_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0}
  };

endpackage

`default_nettype wire

// File: hw/rtl/qau_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface qau_in_if #(parameter int W = qau_pkg::DEF_COMPONENT_BITS) ();
  logic                valid;
  logic                ready;
  logic [2:0]          command;
  logic signed [W-1:0] a_w;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] a_z;
  logic signed [W-1:0] b_w;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] b_z;

  modport source (output valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                  input ready);
  modport sink (input valid, command, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                output ready);
endinterface

interface qau_out_if #(parameter int W = qau_pkg::DEF_COMPONENT_BITS) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result_w;
  logic signed [W-1:0] result_x;
  logic signed [W-1:0] result_y;
  logic signed [W-1:0] result_z;
  logic                saturated;

  modport source (output valid, result_w, result_x, result_y, result_z, saturated,
                  input ready);
  modport sink (input valid, result_w, result_x, result_y, result_z, saturated,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/quaternion_arithmetic_unit.sv
// Quaternion arithmetic unit, signed fixed point (Q16.16 by default).
// operands (valid/ready sink): command plus quaternions a and b. Commands:
//   add, subtract, a*b, conjugate of a, rotate a by b (b*a*conj(b)),
//   magnitude of a (in result_w), normalize a.
// result (valid/ready source): one quaternion and a saturated flag per
//   operand transfer, in order.
// cfg_we/cfg_wdata: writes min_magnitude, the floor applied to |a| before
//   the normalize division. Write only while the unit is empty.
// Fully pipelined: one transfer per cycle while the skid stage is not full.
//   Every command takes the same path length from operand transfer until the
//   result is offered on result.valid; the bit-per-stage square root
//   (COMPONENT_BITS+1 stages) and the bit-per-stage divider
//   (COMPONENT_BITS+FRACTION_BITS stages) set that length.
// The whole pipe moves on one enable. An output register plus a one-entry
//   skid stage sit at the end: while a result waits, one further result can
//   land and operands are still taken; once the skid is full the pipe halts
//   until the receiver takes a result.
// Reset (rst, synchronous) empties the pipe and sets min_magnitude to 66.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_arithmetic_unit #(
  parameter int COMPONENT_BITS = qau_pkg::DEF_COMPONENT_BITS,
  parameter int FRACTION_BITS  = qau_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [qau_pkg::MIN_MAG_BITS-1:0] cfg_wdata,
  qau_in_if.sink                               operands,
  qau_out_if.source                            result
);
  import qau_pkg::*;

  localparam int W  = COMPONENT_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int SQ = W + 3;          // stage holding the root
  localparam int NW = W + F;          // divider stages
  localparam int TF = SQ + NW + 1;    // last pipe stage

  typedef struct packed {
    logic              sat;
    logic [3:0][W-1:0] q;
  } res_t;

  // control
  logic              en;
  logic [TF:0]       v;
  cmd_t              cmd_d [TF+1];
  logic [MIN_MAG_BITS-1:0] min_mag;

  // payload delay lines
  logic [3:0][W-1:0] a_d [SQ+1];
  logic [3:0][W-1:0] b_d [3];
  res_t              res_d [1:TF];

  // lane wiring
  logic [3:0][W-1:0] p1;
  logic [3:0][W:0]   q1;
  logic              rnd1;
  logic [3:0][W-1:0] t;
  logic [3:0]        t_sat;
  logic              t_sat3;
  logic              t_sat4;
  logic [3:0][W:0]   cb;
  logic [3:0][W-1:0] r2;
  logic [3:0]        r2_sat;
  logic [W:0]        root;
  logic [W:0]        den;
  logic [W:0]        floor_m;
  logic [3:0][NW-1:0] num;
  logic [3:0]        a_neg;
  logic [3:0][NW-1:0] quo;
  logic [3:0]        q_neg;

  // combinational results
  res_t              simple_res;
  res_t              mag_res;
  res_t              norm_res;
  logic [W:0]        ext;
  logic [W-1:0]      a_mag;
  logic              ovf;

  // output buffer
  logic              out_valid;
  res_t              out_data;
  logic              sk_valid;
  res_t              sk_data;
  logic              pop;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      min_mag <= MIN_MAG_RESET;
    end else if (cfg_we) begin
      min_mag <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------- pipe
  assign en             = !sk_valid;
  assign operands.ready = en;
  assign pop            = out_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[TF-1:0], operands.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_d[0] <= cmd_t'(operands.command);
      a_d[0]   <= {operands.a_z, operands.a_y, operands.a_x, operands.a_w};
      b_d[0]   <= {operands.b_z, operands.b_y, operands.b_x, operands.b_w};
      for (int k = 1; k <= TF; k++) begin
        cmd_d[k] <= cmd_d[k-1];
      end
      for (int k = 1; k <= SQ; k++) begin
        a_d[k] <= a_d[k-1];
      end
      b_d[1] <= b_d[0];
      b_d[2] <= b_d[1];

      t_sat3 <= |t_sat;
      t_sat4 <= t_sat3;

      // each stage either passes the result on or takes its unit's answer
      res_d[1] <= simple_res;
      res_d[2] <= res_d[1];
      res_d[3] <= (cmd_d[2] == CMD_MUL) ? res_t'{sat: |t_sat, q: t} : res_d[2];
      res_d[4] <= res_d[3];
      res_d[5] <= (cmd_d[4] == CMD_ROT) ? res_t'{sat: t_sat4 | (|r2_sat), q: r2}
                                        : res_d[4];
      for (int k = 6; k <= SQ; k++) begin
        res_d[k] <= res_d[k-1];
      end
      res_d[SQ+1] <= (cmd_d[SQ] == CMD_MAG) ? mag_res : res_d[SQ];
      for (int k = SQ + 2; k < TF; k++) begin
        res_d[k] <= res_d[k-1];
      end
      res_d[TF] <= (cmd_d[TF-1] == CMD_NORM) ? norm_res : res_d[TF-1];
    end
  end

  // add, subtract, conjugate
  always_comb begin
    simple_res = '0;
    ext        = '0;
    ovf        = 1'b0;
    for (int i = 0; i < 4; i++) begin
      unique case (cmd_d[0])
        CMD_ADD:  ext = {a_d[0][i][W-1], a_d[0][i]} + {b_d[0][i][W-1], b_d[0][i]};
        CMD_SUB:  ext = {a_d[0][i][W-1], a_d[0][i]} - {b_d[0][i][W-1], b_d[0][i]};
        CMD_CONJ: ext = (i == 0) ? {a_d[0][i][W-1], a_d[0][i]}
                                 : -{a_d[0][i][W-1], a_d[0][i]};
        default:  ext = '0;
      endcase
      ovf = ext[W] ^ ext[W-1];
      simple_res.q[i] = ovf ? {ext[W], {(W-1){~ext[W]}}} : ext[W-1:0];
      simple_res.sat  = simple_res.sat | ovf;
    end
  end

  // first product: a*b, or b*a with rounding for rotation
  always_comb begin
    rnd1 = (cmd_d[0] == CMD_ROT);
    for (int i = 0; i < 4; i++) begin
      p1[i] = rnd1 ? b_d[0][i] : a_d[0][i];
      q1[i] = rnd1 ? {a_d[0][i][W-1], a_d[0][i]} : {b_d[0][i][W-1], b_d[0][i]};
      cb[i] = (i == 0) ? {b_d[2][i][W-1], b_d[2][i]}
                       : -{b_d[2][i][W-1], b_d[2][i]};
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_lane
    qau_qmul_lane #(.W(W), .F(F), .ROW(r)) u_mul1 (
      .clk (clk),
      .en  (en),
      .rnd (rnd1),
      .p   (p1),
      .q   (q1),
      .res (t[r]),
      .sat (t_sat[r])
    );

    qau_qmul_lane #(.W(W), .F(F), .ROW(r)) u_mul2 (
      .clk (clk),
      .en  (en),
      .rnd (1'b1),
      .p   (t),
      .q   (cb),
      .res (r2[r]),
      .sat (r2_sat[r])
    );

    qau_div_lane #(.W(W), .F(F)) u_div (
      .clk    (clk),
      .en     (en),
      .num    (num[r]),
      .den    (den),
      .neg_in (a_neg[r]),
      .quo    (quo[r]),
      .neg    (q_neg[r])
    );
  end

  qau_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .a    (a_d[0]),
    .root (root)
  );

  // magnitude result and divider operands
  always_comb begin
    mag_res      = '0;
    mag_res.sat  = root[W] | root[W-1];
    mag_res.q[0] = mag_res.sat ? {1'b0, {(W-1){1'b1}}} : root[W-1:0];

    // a zero floor behaves as one
    floor_m = (min_mag == '0) ? (W+1)'(1) : (W+1)'(min_mag);
    den     = (root < floor_m) ? floor_m : root;

    a_mag = '0;
    for (int i = 0; i < 4; i++) begin
      a_neg[i] = a_d[SQ][i][W-1];
      a_mag    = a_neg[i] ? -a_d[SQ][i] : a_d[SQ][i];
      num[i]   = {a_mag, {F{1'b0}}};
    end
  end

  // normalize: restore sign and clamp
  always_comb begin
    norm_res = '0;
    for (int i = 0; i < 4; i++) begin
      if (q_neg[i]) begin
        if ((|quo[i][NW-1:W]) || (quo[i][W-1] && (|quo[i][W-2:0]))) begin
          norm_res.q[i] = {1'b1, {(W-1){1'b0}}};
          norm_res.sat  = 1'b1;
        end else begin
          norm_res.q[i] = -quo[i][W-1:0];
        end
      end else begin
        if (|quo[i][NW-1:W-1]) begin
          norm_res.q[i] = {1'b0, {(W-1){1'b1}}};
          norm_res.sat  = 1'b1;
        end else begin
          norm_res.q[i] = quo[i][W-1:0];
        end
      end
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (pop) begin
        sk_valid <= 1'b0;
      end
    end else if (v[TF]) begin
      if (out_valid && !result.ready) begin
        sk_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (pop) begin
        out_data <= sk_data;
      end
    end else if (v[TF]) begin
      if (out_valid && !result.ready) begin
        sk_data <= res_d[TF];
      end else begin
        out_data <= res_d[TF];
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.result_w  = out_data.q[0];
  assign result.result_x  = out_data.q[1];
  assign result.result_y  = out_data.q[2];
  assign result.result_z  = out_data.q[3];
  assign result.saturated = out_data.sat;

`ifndef ASSERT_OFF
  // the skid only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    sk_valid |-> out_valid)
    else $error("skid holds a result with the output register empty");

  // a halted pipe keeps its last item
  a_tail_held: assert property (@(posedge clk) disable iff (rst)
    (v[TF] && sk_valid && !result.ready) |=> v[TF])
    else $error("pipe tail dropped while halted");

  // magnitude results carry only a non-negative scalar part
  a_mag_shape: assert property (@(posedge clk) disable iff (rst)
    (v[SQ+1] && cmd_d[SQ+1] == CMD_MAG) |->
      (res_d[SQ+1].q[1] == '0 && res_d[SQ+1].q[2] == '0 &&
       res_d[SQ+1].q[3] == '0 && !res_d[SQ+1].q[0][W-1]))
    else $error("magnitude result malformed");

  // the divisor is never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    v[SQ] |-> den != '0)
    else $error("normalize divisor is zero");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/qau_qmul_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// One row of a Hamilton product: four products, then signed sum, optional
// half-LSB rounding, floor shift and clamp. Two register stages.
module qau_qmul_lane #(
  parameter int W   = 32,
  parameter int F   = 16,
  parameter int ROW = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic                 rnd,
  input  wire logic [3:0][W-1:0]    p,
  input  wire logic [3:0][W:0]      q,
  output logic      [W-1:0]         res,
  output logic                      sat
);
  import qau_pkg::*;

  localparam int PW = 2 * W + 1;
  localparam int SW = 2 * W + 3;

  logic signed [PW-1:0] prod [4];
  logic                 rnd_s1;
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] shifted;
  logic                 ovf;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        prod[j] <= $signed(p[j]) * $signed(q[Q_INDEX[ROW][j]]);
      end
      rnd_s1 <= rnd;
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < 4; j++) begin
      if (Q_NEG[ROW][j]) begin
        acc = acc - SW'(prod[j]);
      end else begin
        acc = acc + SW'(prod[j]);
      end
    end
    if (rnd_s1) begin
      acc = acc + (SW'(1) <<< (F - 1));
    end
    shifted = acc >>> F;
    ovf     = !((&shifted[SW-1:W-1]) || !(|shifted[SW-1:W-1]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf) begin
        res <= {shifted[SW-1], {(W-1){~shifted[SW-1]}}};
      end else begin
        res <= shifted[W-1:0];
      end
      sat <= ovf;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/qau_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

// Magnitude of a quaternion: squares, sum, then one root bit per stage.
// W+3 register stages from a to root.
module qau_sqrt #(
  parameter int W = 32
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [3:0][W-1:0] a,
  output logic      [W:0]        root
);
  import qau_pkg::*;

  localparam int TW = 2 * W + 2;
  localparam int RB = W + 1;

  logic [2*W-1:0] sq [4];
  logic [TW-1:0]  sum;
  logic [TW-1:0]  rem_s  [1:RB-1];
  logic [RB-1:0]  root_s [1:RB];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sq[i] <= $signed(a[i]) * $signed(a[i]);
      end
      sum <= TW'(sq[0]) + TW'(sq[1]) + TW'(sq[2]) + TW'(sq[3]);
    end
  end

  for (genvar k = 0; k < RB; k++) begin : g_bit
    localparam int I = W - k;
    logic [TW-1:0] rem_c;
    logic [RB-1:0] root_c;
    logic [TW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_c  = sum;
      assign root_c = '0;
    end else begin : g_next
      assign rem_c  = rem_s[k];
      assign root_c = root_s[k];
    end

    assign trial = (TW'(root_c) << (I + 1)) + (TW'(1) << (2 * I));
    assign ge    = trial <= rem_c;

    always_ff @(posedge clk) begin
      if (en) begin
        root_s[k+1] <= ge ? (root_c | (RB'(1) << I)) : root_c;
      end
    end

    if (k < RB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[k+1] <= ge ? (rem_c - trial) : rem_c;
        end
      end
    end
  end

  assign root = root_s[RB];

endmodule

`default_nettype wire

// File: hw/rtl/qau_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per stage, W+F stages.
module qau_div_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [W+F-1:0]   num,
  input  wire logic [W:0]       den,
  input  wire logic             neg_in,
  output logic      [W+F-1:0]   quo,
  output logic                  neg
);
  import qau_pkg::*;

  localparam int NW = W + F;
  localparam int DW = W + 1;

  logic [DW-1:0] rem_s [1:NW];
  logic [NW-1:0] quo_s [1:NW];
  logic          neg_s [1:NW];
  logic [NW-1:0] num_s [1:NW-1];
  logic [DW-1:0] den_s [1:NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_bit
    logic [DW-1:0] rem_c;
    logic [NW-1:0] quo_c;
    logic [NW-1:0] num_c;
    logic [DW-1:0] den_c;
    logic          neg_c;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_c = '0;
      assign quo_c = '0;
      assign num_c = num;
      assign den_c = den;
      assign neg_c = neg_in;
    end else begin : g_next
      assign rem_c = rem_s[k];
      assign quo_c = quo_s[k];
      assign num_c = num_s[k];
      assign den_c = den_s[k];
      assign neg_c = neg_s[k];
    end

    assign cur  = {rem_c, num_c[NW-1]};
    assign diff = cur - {1'b0, den_c};
    assign ge   = cur >= {1'b0, den_c};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= ge ? diff[DW-1:0] : cur[DW-1:0];
        quo_s[k+1] <= {quo_c[NW-2:0], ge};
        neg_s[k+1] <= neg_c;
      end
    end

    if (k < NW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          num_s[k+1] <= num_c << 1;
          den_s[k+1] <= den_c;
        end
      end
    end
  end

  assign quo = quo_s[NW];
  assign neg = neg_s[NW];

endmodule

`default_nettype wire
